@@ src/vlbp_pkg.sv @@
// shared constants, types and tables of the led bar pattern generator
package vlbp_pkg;

   localparam int NUM_PATTERN_LEDS = 32;

   // field widths
   localparam int FIRST_W   = 12;
   localparam int LEVEL_W   = 16;
   localparam int OPT_W     = 2;
   localparam int PAT_W     = 3;
   localparam int NIB_W     = 12;
   localparam int HUE_IN_W  = 9;
   localparam int PCT_W     = 7;
   localparam int INDEX_W   = 13;
   localparam int HUE_W     = 19;
   localparam int CHAN_W    = 8;

   // internal widths
   localparam int SIZE_W    = LEVEL_W + 1;
   localparam int LED_W     = (NUM_PATTERN_LEDS > 1) ? $clog2(NUM_PATTERN_LEDS) : 1;
   localparam int POS_W     = $clog2(NUM_PATTERN_LEDS + 1);
   localparam int QUO_W     = LED_W;
   localparam int NUM_W     = (LEVEL_W - 1) + POS_W;
   localparam int STEPS     = (QUO_W > 4) ? QUO_W : 4;
   localparam int STEP_W    = $clog2(STEPS);
   localparam int PROD_W    = 11;
   localparam int SCALE_W   = 24;
   localparam int RAINBOW_W = 10;

   // pattern codes
   localparam logic [PAT_W-1:0] PAT_SINGLE  = 3'd0;
   localparam logic [PAT_W-1:0] PAT_THERMO  = 3'd1;
   localparam logic [PAT_W-1:0] PAT_DOT     = 3'd2;
   localparam logic [PAT_W-1:0] PAT_RAINBOW = 3'd3;

   // option bit positions
   localparam int OPT_RADIO  = 0;
   localparam int OPT_DIMMED = 1;

   localparam logic [PCT_W-1:0]        PCT_MAX     = 7'd100;
   localparam logic [PCT_W-1:0]        RAINBOW_SAT = 7'd100;
   localparam logic [PCT_W-1:0]        RAINBOW_BRI = 7'd10;
   localparam logic signed [HUE_W-1:0] HUE_MAX     = 19'sd131071;
   localparam int                      CHAN_COUNT  = 3;

   // x / 100 as (x * 5243) >> 19, channel carries an extra factor of 16
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 15;

   localparam int RAINBOW_SPAN = 800;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_PREP,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef logic [RAINBOW_W-1:0] hue_tab_type [NUM_PATTERN_LEDS];

   function automatic hue_tab_type make_rainbow();
      hue_tab_type tab;
      for (int i = 0; i < NUM_PATTERN_LEDS; i++) begin
         tab[i] = RAINBOW_W'(RAINBOW_SPAN - (RAINBOW_SPAN * i) / NUM_PATTERN_LEDS);
      end
      return tab;
   endfunction

   localparam hue_tab_type RAINBOW_HUE = make_rainbow();

endpackage

@@ src/vlbp_req_if.sv @@
// input channel of the led bar pattern generator
interface vlbp_req_if import vlbp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [FIRST_W-1:0]         first_led;
   logic signed [LEVEL_W-1:0]  level;
   logic signed [LEVEL_W-1:0]  range_min;
   logic signed [LEVEL_W-1:0]  range_max;
   logic [OPT_W-1:0]           options;
   logic [PAT_W-1:0]           pattern;
   logic [NIB_W-1:0]           rgb_nibbles;
   logic [HUE_IN_W-1:0]        hue_in;
   logic [PCT_W-1:0]           saturation_in;
   logic [PCT_W-1:0]           brightness_in;

   modport source (
      output valid, first_led, level, range_min, range_max, options, pattern,
             rgb_nibbles, hue_in, saturation_in, brightness_in,
      input  ready
   );
   modport sink (
      input  valid, first_led, level, range_min, range_max, options, pattern,
             rgb_nibbles, hue_in, saturation_in, brightness_in,
      output ready
   );
endinterface

@@ src/vlbp_rsp_if.sv @@
// result channel of the led bar pattern generator
interface vlbp_rsp_if import vlbp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [INDEX_W-1:0]       led_index;
   logic                     is_hsv;
   logic signed [HUE_W-1:0]  hue_quarter_deg;
   logic [PCT_W-1:0]         saturation_pct;
   logic [PCT_W-1:0]         brightness_pct;
   logic [CHAN_W-1:0]        red;
   logic [CHAN_W-1:0]        green;
   logic [CHAN_W-1:0]        blue;
   logic                     last;

   modport source (
      output valid, led_index, is_hsv, hue_quarter_deg, saturation_pct,
             brightness_pct, red, green, blue, last,
      input  ready
   );
   modport sink (
      input  valid, led_index, is_hsv, hue_quarter_deg, saturation_pct,
             brightness_pct, red, green, blue, last,
      output ready
   );
endinterface

@@ src/value_to_led_bar_pattern.sv @@
// led bar pattern generator: maps a level into a bar and emits per-led colors
//
//  channel   direction  handshake     beat
//  req_ch    in         valid/ready   one control item
//  rsp_ch    out        valid/ready   one led color, last on final led
//
// an item is accepted in idle, then passes the map state, the prep state and STEPS (5 at 32 leds)
// steps of the bit-serial divider, then gives one result per cycle while rsp_ch does not
// stall: one beat per led for a bar of 32 leds, a single beat for the single pattern.
// the divider loop yields one quotient bit per cycle, with the dim scaling riding along, and
// the emit state sends one beat per led.
// req_ch.ready is high only while idle; a stalled rsp_ch holds the output register
// and freezes the led counter. reset returns to idle with no result pending.
module value_to_led_bar_pattern import vlbp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   vlbp_req_if.sink     req_ch,
   vlbp_rsp_if.source   rsp_ch
);

   state_type state_ff, state_in;

   // captured item
   logic [FIRST_W-1:0]        first_ff, first_in;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic signed [LEVEL_W-1:0] min_ff, min_in;
   logic signed [LEVEL_W-1:0] max_ff, max_in;
   logic [OPT_W-1:0]          opt_ff, opt_in;
   logic [PAT_W-1:0]          pat_ff, pat_in;
   logic [NIB_W-1:0]          nib_ff, nib_in;
   logic [HUE_IN_W-1:0]       hin_ff, hin_in;
   logic [PCT_W-1:0]          sin_ff, sin_in;
   logic [PCT_W-1:0]          vin_ff, vin_in;

   // mapped level and range size
   logic signed [LEVEL_W-1:0] lv_ff, lv_in;
   logic [SIZE_W-1:0]         size_ff, size_in;

   // prepared color and divider state
   logic [PCT_W-1:0]          dim_ff, dim_in;
   logic                      pos_zero_ff, pos_zero_in;
   logic                      pos_sat_ff, pos_sat_in;
   logic [SIZE_W-1:0]         rem_ff, rem_in;
   logic [QUO_W-1:0]          nq_ff, nq_in;
   logic                      hsv_ff, hsv_in;
   logic signed [HUE_W-1:0]   hue_ff, hue_in;
   logic [PCT_W-1:0]          sat_ff, sat_in;
   logic [PCT_W-1:0]          bri_ff, bri_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [CHAN_W-1:0]         red_ff, red_in;
   logic [CHAN_W-1:0]         green_ff, green_in;
   logic [CHAN_W-1:0]         blue_ff, blue_in;
   logic [LED_W-1:0]          led_ff, led_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic                      rsp_hsv_ff, rsp_hsv_in;
   logic signed [HUE_W-1:0]   rsp_hue_ff, rsp_hue_in;
   logic [PCT_W-1:0]          rsp_sat_ff, rsp_sat_in;
   logic [PCT_W-1:0]          rsp_bri_ff, rsp_bri_in;
   logic [CHAN_W-1:0]         rsp_red_ff, rsp_red_in;
   logic [CHAN_W-1:0]         rsp_green_ff, rsp_green_in;
   logic [CHAN_W-1:0]         rsp_blue_ff, rsp_blue_in;
   logic                      rsp_last_ff, rsp_last_in;

   // control
   logic accept;
   logic out_load;
   logic div_done;
   logic last_led;

   // ---------------------------------------------------------------- map logic
   logic signed [SIZE_W-1:0]  val_ext, min_ext, max_ext, sum_ext, dif_ext, span_ext;
   logic signed [LEVEL_W-1:0] lo_b, hi_b, lv_map;
   logic [SIZE_W-1:0]         abs_span, size_calc;

   assign val_ext  = $signed({level_ff[LEVEL_W-1], level_ff});
   assign min_ext  = $signed({min_ff[LEVEL_W-1], min_ff});
   assign max_ext  = $signed({max_ff[LEVEL_W-1], max_ff});
   assign sum_ext  = min_ext + val_ext;
   assign dif_ext  = min_ext - val_ext;
   assign span_ext = max_ext - min_ext;
   assign abs_span = span_ext[SIZE_W-1] ? SIZE_W'(-span_ext) : SIZE_W'(span_ext);
   assign size_calc = abs_span + SIZE_W'(1);

   always_comb begin
      lo_b = (min_ff <= max_ff) ? min_ff : max_ff;
      hi_b = (min_ff <= max_ff) ? max_ff : min_ff;
      if (opt_ff[OPT_RADIO]) begin
         lv_map = (level_ff >= lo_b && level_ff <= hi_b) ? level_ff : '0;
      end else if (min_ff == max_ff) begin
         lv_map = (level_ff == min_ff) ? level_ff : '0;
      end else if (min_ff < max_ff) begin
         if (sum_ext < min_ext) begin
            lv_map = min_ff;
         end else if (sum_ext > max_ext) begin
            lv_map = max_ff;
         end else begin
            lv_map = sum_ext[LEVEL_W-1:0];
         end
      end else begin
         // reverse sweep
         if (dif_ext < max_ext) begin
            lv_map = max_ff;
         end else if (dif_ext > min_ext) begin
            lv_map = min_ff;
         end else begin
            lv_map = dif_ext[LEVEL_W-1:0];
         end
      end
   end

   // --------------------------------------------------------------- prep logic
   logic                      lv_pos;
   logic [NUM_W-1:0]          num;
   logic [PCT_W-1:0]          dim_calc;
   logic                      hsv_raw;
   logic signed [SIZE_W-1:0]  hsum;
   logic signed [HUE_W-1:0]   hue_lv, hue_lv_sat, hue_base;

   assign lv_pos  = !lv_ff[LEVEL_W-1] && (lv_ff != '0);
   assign num     = NUM_W'(lv_ff[LEVEL_W-2:0]) * NUM_W'(NUM_PATTERN_LEDS);
   assign hsv_raw = (nib_ff == '0);
   assign hsum    = $signed({lv_ff[LEVEL_W-1], lv_ff}) + $signed({8'd0, hin_ff});
   assign hue_lv  = $signed({hsum, 2'b00});
   assign hue_lv_sat = (hue_lv > HUE_MAX) ? HUE_MAX : hue_lv;
   assign hue_base = $signed({8'd0, hin_ff, 2'b00});

   always_comb begin
      if (lv_ff > $signed(LEVEL_W'(PCT_MAX))) begin
         dim_calc = PCT_MAX;
      end else if (lv_ff[LEVEL_W-1]) begin
         dim_calc = '0;
      end else begin
         dim_calc = lv_ff[PCT_W-1:0];
      end
   end

   // ------------------------------------------------------------ divider step
   logic [SIZE_W:0]   trial, trial_sub;
   logic              ge;
   logic [QUO_W:0]    nq_shift;

   assign trial     = {rem_ff, nq_ff[QUO_W-1]};
   assign ge        = trial >= {1'b0, size_ff};
   assign trial_sub = trial - {1'b0, size_ff};
   assign nq_shift  = {nq_ff, ge};

   // ------------------------------------------------------ channel dim scaling
   logic [1:0]         prod_sel, chan_sel;
   logic [3:0]         nib_a, nib_b;
   logic [PROD_W-1:0]  prod_calc;
   logic [SCALE_W-1:0] scale_prod;
   logic [CHAN_W-1:0]  chan_val;

   assign prod_sel = step_ff[1:0];
   assign chan_sel = step_ff[1:0] - 2'd1;

   always_comb begin
      case (prod_sel)
         2'd0:    nib_a = nib_ff[3:0];
         2'd1:    nib_a = nib_ff[7:4];
         2'd2:    nib_a = nib_ff[11:8];
         default: nib_a = '0;
      endcase
      case (chan_sel)
         2'd0:    nib_b = nib_ff[3:0];
         2'd1:    nib_b = nib_ff[7:4];
         2'd2:    nib_b = nib_ff[11:8];
         default: nib_b = '0;
      endcase
   end

   assign prod_calc  = PROD_W'(nib_a) * PROD_W'(dim_ff);
   assign scale_prod = SCALE_W'(prod_ff) * SCALE_W'(RECIP_100);

   always_comb begin
      if (lv_ff == '0) begin
         chan_val = '0;
      end else if (opt_ff[OPT_DIMMED]) begin
         chan_val = CHAN_W'(scale_prod >> RECIP_SHIFT);
      end else begin
         chan_val = {nib_b, 4'b0000};
      end
   end

   // --------------------------------------------------------------- led emit
   logic [POS_W-1:0]   pos_val, led_ext;
   logic               blank;
   logic [INDEX_W-1:0] led_index_calc;

   assign pos_val = pos_zero_ff ? '0 :
                    (pos_sat_ff ? POS_W'(NUM_PATTERN_LEDS) : POS_W'(nq_ff));
   assign led_ext = POS_W'(led_ff);
   assign led_index_calc = INDEX_W'(first_ff) + INDEX_W'(led_ff);
   assign last_led = (pat_ff == PAT_SINGLE) || (led_ff == LED_W'(NUM_PATTERN_LEDS - 1));

   always_comb begin
      case (pat_ff)
         PAT_THERMO:  blank = led_ext > pos_val;
         PAT_DOT:     blank = led_ext != pos_val;
         PAT_RAINBOW: blank = led_ext > pos_val;
         default:     blank = 1'b0;
      endcase
   end

   // ------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MAP;
         end
         ST_MAP:  state_in = ST_PREP;
         ST_PREP: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_load && last_led) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      req_ch.ready = 1'b0;
      out_load     = 1'b0;
      div_done     = 1'b0;
      case (state_ff)
         ST_IDLE: req_ch.ready = 1'b1;
         ST_DIV:  div_done = (step_ff == STEP_W'(STEPS - 1));
         ST_EMIT: out_load = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   assign accept = req_ch.valid && req_ch.ready;

   // ---------------------------------------------------------------- datapath
   always_comb begin
      first_in = first_ff;
      level_in = level_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      opt_in   = opt_ff;
      pat_in   = pat_ff;
      nib_in   = nib_ff;
      hin_in   = hin_ff;
      sin_in   = sin_ff;
      vin_in   = vin_ff;
      lv_in    = lv_ff;
      size_in  = size_ff;
      dim_in   = dim_ff;
      pos_zero_in = pos_zero_ff;
      pos_sat_in  = pos_sat_ff;
      rem_in   = rem_ff;
      nq_in    = nq_ff;
      hsv_in   = hsv_ff;
      hue_in   = hue_ff;
      sat_in   = sat_ff;
      bri_in   = bri_ff;
      step_in  = step_ff;
      prod_in  = prod_ff;
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      led_in   = led_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               first_in = req_ch.first_led;
               level_in = req_ch.level;
               min_in   = req_ch.range_min;
               max_in   = req_ch.range_max;
               opt_in   = req_ch.options;
               pat_in   = req_ch.pattern;
               nib_in   = req_ch.rgb_nibbles;
               hin_in   = req_ch.hue_in;
               sin_in   = req_ch.saturation_in;
               vin_in   = req_ch.brightness_in;
            end
         end
         ST_MAP: begin
            lv_in   = lv_map;
            size_in = size_calc;
         end
         ST_PREP: begin
            dim_in      = dim_calc;
            pos_zero_in = !lv_pos;
            pos_sat_in  = lv_pos && ({1'b0, lv_ff} >= size_ff);
            // numerator top bits seed the remainder, low bits shift in
            rem_in      = SIZE_W'(num >> QUO_W);
            nq_in       = num[QUO_W-1:0];
            step_in     = '0;
            led_in      = '0;
            sat_in      = (sin_ff > PCT_MAX) ? PCT_MAX : sin_ff;
            if (opt_ff[OPT_DIMMED]) begin
               hue_in = hue_base;
               bri_in = dim_calc;
            end else begin
               hue_in = (pat_ff == PAT_SINGLE) ? hue_lv_sat : hue_base;
               bri_in = (vin_ff > PCT_MAX) ? PCT_MAX : vin_ff;
            end
            hsv_in = hsv_raw;
            if (pat_ff == PAT_RAINBOW && !hsv_raw) begin
               hsv_in = 1'b1;
               sat_in = RAINBOW_SAT;
               bri_in = RAINBOW_BRI;
            end
         end
         ST_DIV: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff < STEP_W'(QUO_W)) begin
               rem_in = ge ? trial_sub[SIZE_W-1:0] : trial[SIZE_W-1:0];
               nq_in  = nq_shift[QUO_W-1:0];
            end
            if (step_ff < STEP_W'(CHAN_COUNT)) begin
               prod_in = prod_calc;
            end
            // one channel lands a step after its product
            if (step_ff >= STEP_W'(1) && step_ff <= STEP_W'(CHAN_COUNT)) begin
               case (chan_sel)
                  2'd0:    red_in   = chan_val;
                  2'd1:    green_in = chan_val;
                  default: blue_in  = chan_val;
               endcase
            end
         end
         ST_EMIT: begin
            if (out_load) led_in = led_ff + LED_W'(1);
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------- output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_index_in = rsp_index_ff;
      rsp_hsv_in   = rsp_hsv_ff;
      rsp_hue_in   = rsp_hue_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_bri_in   = rsp_bri_ff;
      rsp_red_in   = rsp_red_ff;
      rsp_green_in = rsp_green_ff;
      rsp_blue_in  = rsp_blue_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = led_index_calc;
         rsp_hsv_in   = hsv_ff;
         rsp_last_in  = last_led;
         if (hsv_ff) begin
            rsp_hue_in   = (pat_ff == PAT_RAINBOW) ?
                           $signed(HUE_W'(RAINBOW_HUE[led_ff])) : hue_ff;
            rsp_sat_in   = sat_ff;
            rsp_bri_in   = blank ? '0 : bri_ff;
            rsp_red_in   = '0;
            rsp_green_in = '0;
            rsp_blue_in  = '0;
         end else begin
            rsp_hue_in   = '0;
            rsp_sat_in   = '0;
            rsp_bri_in   = '0;
            rsp_red_in   = blank ? '0 : red_ff;
            rsp_green_in = blank ? '0 : green_ff;
            rsp_blue_in  = blank ? '0 : blue_ff;
         end
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.led_index       = rsp_index_ff;
   assign rsp_ch.is_hsv          = rsp_hsv_ff;
   assign rsp_ch.hue_quarter_deg = rsp_hue_ff;
   assign rsp_ch.saturation_pct  = rsp_sat_ff;
   assign rsp_ch.brightness_pct  = rsp_bri_ff;
   assign rsp_ch.red             = rsp_red_ff;
   assign rsp_ch.green           = rsp_green_ff;
   assign rsp_ch.blue            = rsp_blue_ff;
   assign rsp_ch.last            = rsp_last_ff;

   // --------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      level_ff     <= level_in;
      min_ff       <= min_in;
      max_ff       <= max_in;
      opt_ff       <= opt_in;
      pat_ff       <= pat_in;
      nib_ff       <= nib_in;
      hin_ff       <= hin_in;
      sin_ff       <= sin_in;
      vin_ff       <= vin_in;
      lv_ff        <= lv_in;
      size_ff      <= size_in;
      dim_ff       <= dim_in;
      pos_zero_ff  <= pos_zero_in;
      pos_sat_ff   <= pos_sat_in;
      rem_ff       <= rem_in;
      nq_ff        <= nq_in;
      hsv_ff       <= hsv_in;
      hue_ff       <= hue_in;
      sat_ff       <= sat_in;
      bri_ff       <= bri_in;
      step_ff      <= step_in;
      prod_ff      <= prod_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      led_ff       <= led_in;
      rsp_index_ff <= rsp_index_in;
      rsp_hsv_ff   <= rsp_hsv_in;
      rsp_hue_ff   <= rsp_hue_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_bri_ff   <= rsp_bri_in;
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // -------------------------------------------------------------- assertions
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("input taken while an item is in flight");

   a_rgb_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.is_hsv) |->
         (rsp_ch.hue_quarter_deg == '0 && rsp_ch.saturation_pct == '0 &&
          rsp_ch.brightness_pct == '0))
      else $error("hsv fields set on an rgb beat");

   a_hsv_fields_sane: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.is_hsv) |->
         (rsp_ch.red == '0 && rsp_ch.green == '0 && rsp_ch.blue == '0 &&
          rsp_ch.saturation_pct <= PCT_MAX && rsp_ch.brightness_pct <= PCT_MAX))
      else $error("bad color fields on an hsv beat");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_led) |=> (state_ff == ST_IDLE && rsp_ch.last))
      else $error("sequencer did not finish after the last beat");

endmodule

@@ test/value_to_led_bar_pattern_test.sv @@
// testbench of the led bar pattern generator: directed and random items, predicted led colors
`timescale 1ns / 1ps

module value_to_led_bar_pattern_test;
   import vlbp_pkg::*;

   typedef struct {
      logic [FIRST_W-1:0]        first_led;
      logic signed [LEVEL_W-1:0] level;
      logic signed [LEVEL_W-1:0] range_min;
      logic signed [LEVEL_W-1:0] range_max;
      logic [OPT_W-1:0]          options;
      logic [PAT_W-1:0]          pattern;
      logic [NIB_W-1:0]          rgb_nibbles;
      logic [HUE_IN_W-1:0]       hue_in;
      logic [PCT_W-1:0]          saturation_in;
      logic [PCT_W-1:0]          brightness_in;
   } bar_item_type;

   typedef struct packed {
      logic [INDEX_W-1:0] led_index;
      logic               is_hsv;
      logic [HUE_W-1:0]   hue_quarter_deg;
      logic [PCT_W-1:0]   saturation_pct;
      logic [PCT_W-1:0]   brightness_pct;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
      logic               last;
   } led_color_type;

   localparam int OPTS_RADIO  = 1 << OPT_RADIO;
   localparam int OPTS_DIMMED = 1 << OPT_DIMMED;
   localparam int HUE_MIN     = -int'(HUE_MAX) - 1;
   localparam int RANDOM_ITEMS = 105;

   logic clock;
   logic reset;

   vlbp_req_if req_ch ();
   vlbp_rsp_if rsp_ch ();

   value_to_led_bar_pattern dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   led_color_type led_colors_due[$];
   int            mismatch_count = 0;
   bit            send_idle_on = 1;
   bit            sink_idle_on = 1;
   bit            rsp_beat_seen = 0;
   int            rsp_stall = 0;

   always begin
      clock = 0;
      #1;
      clock = 1;
      #1;
   end

   function automatic bar_item_type bar_item(int first, int lvl, int lo, int hi, int opt,
                                             int pat, int nib, int hue, int sat, int bri);
      bar_item_type it;
      it.first_led     = FIRST_W'(first);
      it.level         = LEVEL_W'(lvl);
      it.range_min     = LEVEL_W'(lo);
      it.range_max     = LEVEL_W'(hi);
      it.options       = OPT_W'(opt);
      it.pattern       = PAT_W'(pat);
      it.rgb_nibbles   = NIB_W'(nib);
      it.hue_in        = HUE_IN_W'(hue);
      it.saturation_in = PCT_W'(sat);
      it.brightness_in = PCT_W'(bri);
      return it;
   endfunction

   // expands one item into the led colors it should produce
   function automatic void predict_leds(input bar_item_type it);
      int            val, mn, mx, lv, dim, lo, hi;
      int            c1, c2, c3, a, b, c, h;
      longint        size, pos;
      bit            radio, dimmed, hsv, blank, fin;
      led_color_type exp;
      val    = it.level;
      mn     = it.range_min;
      mx     = it.range_max;
      radio  = it.options[OPT_RADIO];
      dimmed = it.options[OPT_DIMMED];
      lo     = (mn <= mx) ? mn : mx;
      hi     = (mn <= mx) ? mx : mn;
      if (radio) begin
         lv = (val >= lo && val <= hi) ? val : 0;
      end else if (mn == mx) begin
         lv = (val == mn) ? val : 0;
      end else if (mn < mx) begin
         lv = mn + val;
         lv = (lv < mn) ? mn : ((lv > mx) ? mx : lv);
      end else begin
         // reverse sweep
         lv = mn - val;
         lv = (lv < mx) ? mx : ((lv > mn) ? mn : lv);
      end
      size = longint'(hi) - lo + 1;
      pos  = (lv > 0) ? (longint'(NUM_PATTERN_LEDS) * lv) / size : 0;
      dim  = (lv > int'(PCT_MAX)) ? int'(PCT_MAX) : ((lv < 0) ? 0 : lv);

      hsv = (it.rgb_nibbles == '0);
      if (!hsv) begin
         c1 = int'(it.rgb_nibbles[3:0]) * 16;
         c2 = int'(it.rgb_nibbles[7:4]) * 16;
         c3 = int'(it.rgb_nibbles[11:8]) * 16;
         if (lv == 0) begin
            c1 = 0;
            c2 = 0;
            c3 = 0;
         end else if (dimmed) begin
            c1 = c1 * dim / 100;
            c2 = c2 * dim / 100;
            c3 = c3 * dim / 100;
         end
      end else begin
         c2 = (it.saturation_in > PCT_MAX) ? int'(PCT_MAX) : int'(it.saturation_in);
         if (dimmed) begin
            c1 = int'(it.hue_in) * 4;
            c3 = dim;
         end else begin
            c1 = ((it.pattern == PAT_SINGLE) ? lv + int'(it.hue_in) : int'(it.hue_in)) * 4;
            c3 = (it.brightness_in > PCT_MAX) ? int'(PCT_MAX) : int'(it.brightness_in);
         end
      end
      // rainbow always goes out as hsv
      if (it.pattern == PAT_RAINBOW && !hsv) begin
         hsv = 1;
         c2  = RAINBOW_SAT;
         c3  = RAINBOW_BRI;
      end

      for (int led = 0; led < NUM_PATTERN_LEDS; led++) begin
         a     = c1;
         b     = c2;
         c     = c3;
         blank = 0;
         if (it.pattern == PAT_THERMO) begin
            blank = longint'(led) > pos;
         end else if (it.pattern == PAT_DOT) begin
            blank = longint'(led) != pos;
         end else if (it.pattern == PAT_RAINBOW) begin
            a     = RAINBOW_SPAN - (RAINBOW_SPAN * led) / NUM_PATTERN_LEDS;
            blank = longint'(led) > pos;
         end
         if (blank) begin
            if (hsv) begin
               c = 0;
            end else begin
               a = 0;
               b = 0;
               c = 0;
            end
         end
         fin = (it.pattern == PAT_SINGLE) || (led == NUM_PATTERN_LEDS - 1);
         exp.led_index = INDEX_W'(int'(it.first_led) + led);
         exp.is_hsv    = hsv;
         if (hsv) begin
            h = (a < HUE_MIN) ? HUE_MIN : ((a > int'(HUE_MAX)) ? int'(HUE_MAX) : a);
            exp.hue_quarter_deg = HUE_W'(h);
            exp.saturation_pct  = PCT_W'(b);
            exp.brightness_pct  = PCT_W'(c);
            exp.red   = '0;
            exp.green = '0;
            exp.blue  = '0;
         end else begin
            exp.hue_quarter_deg = '0;
            exp.saturation_pct  = '0;
            exp.brightness_pct  = '0;
            exp.red   = CHAN_W'(a);
            exp.green = CHAN_W'(b);
            exp.blue  = CHAN_W'(c);
         end
         exp.last = fin;
         led_colors_due.push_back(exp);
         if (fin) break;
      end
   endfunction

   function automatic string led_text(input led_color_type l);
      return $sformatf("idx=%0d hsv=%0d hue=%0d sat=%0d bri=%0d rgb=%0d/%0d/%0d last=%0d",
                       l.led_index, l.is_hsv, $signed(l.hue_quarter_deg), l.saturation_pct,
                       l.brightness_pct, l.red, l.green, l.blue, l.last);
   endfunction

   // result checker
   always @(posedge clock) begin
      led_color_type got, exp;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_beat_seen = 1;
         got.led_index       = rsp_ch.led_index;
         got.is_hsv          = rsp_ch.is_hsv;
         got.hue_quarter_deg = rsp_ch.hue_quarter_deg;
         got.saturation_pct  = rsp_ch.saturation_pct;
         got.brightness_pct  = rsp_ch.brightness_pct;
         got.red             = rsp_ch.red;
         got.green           = rsp_ch.green;
         got.blue            = rsp_ch.blue;
         got.last            = rsp_ch.last;
         if (led_colors_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected led beat, expected none, got %s", $time, led_text(got));
         end else begin
            exp = led_colors_due.pop_front();
            if (got !== exp) begin
               mismatch_count++;
               $display("%0t: led mismatch, expected %s, got %s", $time,
                        led_text(exp), led_text(got));
            end
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (rsp_beat_seen) begin
         rsp_stall     = sink_idle_on ? $urandom_range(5, 0) : 0;
         rsp_beat_seen = 0;
      end
      if (rsp_stall > 0) begin
         rsp_ch.ready = 0;
         rsp_stall--;
      end else begin
         rsp_ch.ready = 1;
      end
   end

   task automatic send_bar(input bar_item_type it);
      int gap;
      gap = send_idle_on ? $urandom_range(5, 0) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_ch.first_led     = it.first_led;
      req_ch.level         = it.level;
      req_ch.range_min     = it.range_min;
      req_ch.range_max     = it.range_max;
      req_ch.options       = it.options;
      req_ch.pattern       = it.pattern;
      req_ch.rgb_nibbles   = it.rgb_nibbles;
      req_ch.hue_in        = it.hue_in;
      req_ch.saturation_in = it.saturation_in;
      req_ch.brightness_in = it.brightness_in;
      req_ch.valid         = 1;
      do @(posedge clock); while (!req_ch.ready);
      predict_leds(it);
   endtask

   task automatic drain_leds();
      @(negedge clock);
      req_ch.valid = 0;
      while (led_colors_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_bar_patterns();
      send_bar(bar_item(0, 0, 0, 31, 0, PAT_THERMO, 'h000, 0, 0, 0));
      send_bar(bar_item(4095, 31, 0, 31, 0, PAT_THERMO, 'hFFF, 359, 100, 100));
      send_bar(bar_item(100, 10, 0, 31, OPTS_DIMMED, PAT_DOT, 'h123, 45, 60, 70));
      send_bar(bar_item(7, 16, 0, 31, 0, PAT_RAINBOW, 'hABC, 10, 20, 30));
      send_bar(bar_item(7, 50, 0, 99, OPTS_DIMMED, PAT_RAINBOW, 'h000, 200, 80, 60));
      // plain fill patterns
      for (int p = PAT_RAINBOW + 1; p < (1 << PAT_W); p++) begin
         send_bar(bar_item(p * 3, 20, 0, 63, 0, p, (p % 2) ? 'h5A5 : 'h000, 120, 50, 70));
      end
      send_bar(bar_item(2048, 3, 0, 31, 0, PAT_SINGLE, 'h000, 359, 100, 100));
   endtask

   task automatic test_level_mapping();
      send_bar(bar_item(0, 5, 5, 5, 0, PAT_THERMO, 'h0F0, 0, 0, 0));
      send_bar(bar_item(0, 6, 5, 5, 0, PAT_THERMO, 'h0F0, 0, 0, 0));
      send_bar(bar_item(0, 10, 31, 0, 0, PAT_DOT, 'h000, 90, 100, 100));
      send_bar(bar_item(0, -40, 31, 0, 0, PAT_THERMO, 'h000, 90, 100, 100));
      send_bar(bar_item(0, 40, 31, 0, 0, PAT_THERMO, 'h321, 90, 100, 100));
      send_bar(bar_item(0, 200, -100, 100, OPTS_RADIO, PAT_THERMO, 'hF0F, 0, 0, 0));
      send_bar(bar_item(0, -20, 100, -100, OPTS_RADIO, PAT_DOT, 'h000, 300, 40, 40));
   endtask

   task automatic test_edge_cases();
      // negative mapped level: bar position stays at zero
      send_bar(bar_item(0, -50, -100, 100, OPTS_RADIO, PAT_THERMO, 'h000, 30, 50, 50));
      // negative dimmed level in both color modes
      send_bar(bar_item(0, -50, -100, 100, OPTS_RADIO | OPTS_DIMMED, PAT_DOT,
                        'h000, 90, 50, 50));
      send_bar(bar_item(0, -50, -100, 100, OPTS_RADIO | OPTS_DIMMED, PAT_DOT,
                        'hFFF, 90, 50, 50));
      // percents above 100
      send_bar(bar_item(0, 10, 0, 31, 0, PAT_THERMO, 'h000, 10, 127, 127));
      // hue past HUE_MAX at the top end, and at its lowest value at the bottom end
      send_bar(bar_item(0, 32767, -32768, 32767, OPTS_RADIO, PAT_SINGLE, 'h000, 359, 50, 50));
      send_bar(bar_item(0, -32768, -32768, 32767, OPTS_RADIO, PAT_SINGLE, 'h000, 0, 50, 50));
      // dim level above 100 and the most negative offset
      send_bar(bar_item(0, 500, 0, 1000, OPTS_DIMMED, PAT_THERMO, 'hFFF, 0, 0, 0));
      send_bar(bar_item(0, -32768, -32768, 32767, 0, PAT_THERMO, 'h001, 0, 0, 0));
   endtask

   function automatic bar_item_type random_bar(bit noisy);
      bar_item_type it;
      int           mn, mx, lvl;
      if (noisy) begin
         return bar_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
      end
      mn = int'($urandom_range(100)) - 50;
      case ($urandom_range(3))
         0: mx = mn;
         1: mx = mn - int'($urandom_range(64));
         default: mx = mn + int'($urandom_range(64));
      endcase
      case ($urandom_range(5))
         0: lvl = mn;
         1: lvl = mx;
         2: lvl = int'($urandom_range(2000)) - 1000;
         default: lvl = int'($urandom_range(140)) - 70;
      endcase
      it = bar_item($urandom_range(4095), lvl, mn, mx, $urandom_range(3),
                    ($urandom_range(3) == 0) ? $urandom_range(7, 4) : $urandom_range(3),
                    $urandom_range(1) ? $urandom_range(4095, 1) : 0,
                    ($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(359),
                    ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(100),
                    ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(100));
      return it;
   endfunction

   task automatic test_random_traffic();
      send_idle_on = 0;
      sink_idle_on = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // a run at full rate first, then random gaps on both sides
         if (n == 25) begin
            send_idle_on = 1;
            sink_idle_on = 1;
         end
         if (n == RANDOM_ITEMS / 2) drain_leds();
         send_bar(random_bar($urandom_range(4) == 0));
      end
   endtask

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      reset                = 1;
      req_ch.valid         = 0;
      req_ch.first_led     = '0;
      req_ch.level         = '0;
      req_ch.range_min     = '0;
      req_ch.range_max     = '0;
      req_ch.options       = '0;
      req_ch.pattern       = '0;
      req_ch.rgb_nibbles   = '0;
      req_ch.hue_in        = '0;
      req_ch.saturation_in = '0;
      req_ch.brightness_in = '0;
      rsp_ch.ready         = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      test_bar_patterns();
      drain_leds();
      test_level_mapping();
      drain_leds();
      test_edge_cases();
      drain_leds();
      test_random_traffic();
      drain_leds();
      // room for any stray beat to show up
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
